### rtl/rfru_pkg.sv
// Package for the false-position root finder: status codes, register map and FSM states.
// No dependencies.
package rfru_pkg;

    localparam int unsigned REG_ADDR_W = 5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_BRACKET = 2'd1,
        ST_ITER_LIMIT = 2'd2,
        ST_RSVD       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_CUBIC  = 3'd0,
        REG_SQUARE = 3'd1,
        REG_LINEAR = 3'd2,
        REG_CONST  = 3'd3,
        REG_TOL    = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL_LO,
        S_EVAL_HI,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_STEP,
        S_EVAL_X,
        S_TEST,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_X0 = 2'd0,
        SEL_X1 = 2'd1,
        SEL_X  = 2'd2
    } t_eval_sel;

    typedef enum logic [1:0] {
        RES_LO_ZERO    = 2'd0,
        RES_HI_ZERO    = 2'd1,
        RES_NO_BRACKET = 2'd2,
        RES_CHORD      = 2'd3
    } t_res_kind;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;      // capture request guesses
        logic       eval_start;
        t_eval_sel  eval_sel;
        logic       store_f0;
        logic       store_f1;
        logic       mul_start;
        logic       div_start;
        logic       step;      // form x from quotient
        logic       store_f;
        logic       keep;      // replace one bracket end
        logic       set_res;
        t_res_kind  res_kind;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic eval_done;
        logic mul_done;
        logic div_done;
        logic f0_zero;
        logic f1_zero;
        logic same_sign;
        logic within_tol;
    } t_stat;

endpackage

### rtl/rfru_if.sv
// Valid/ready channel interface carrying the request and result payloads.
// Depends on nothing.
interface rfru_req_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [DW-1:0] guess_low;
    logic [DW-1:0] guess_high;
    modport source (output valid, guess_low, guess_high, input ready);
    modport sink   (input valid, guess_low, guess_high, output ready);
endinterface

interface rfru_res_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [DW-1:0] root;
    logic [DW-1:0] residual;
    logic [6:0]    iterations;
    logic [1:0]    status;
    modport source (output valid, root, residual, iterations, status, input ready);
    modport sink   (input valid, root, residual, iterations, status, output ready);
endinterface

### rtl/rfru_datapath.sv
// Datapath: bracket registers, Horner evaluator on one multiplier, chord product and
// serial divider. Depends on rfru_pkg.
module rfru_datapath
    import rfru_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic signed [DATA_WIDTH-1:0] i_guess_low,
    input  logic signed [DATA_WIDTH-1:0] i_guess_high,
    input  logic signed [DATA_WIDTH-1:0] i_c3,
    input  logic signed [DATA_WIDTH-1:0] i_c2,
    input  logic signed [DATA_WIDTH-1:0] i_c1,
    input  logic signed [DATA_WIDTH-1:0] i_c0,
    input  logic        [DATA_WIDTH-2:0] i_tol,
    output logic signed [DATA_WIDTH-1:0] o_root,
    output logic signed [DATA_WIDTH-1:0] o_residual
);
    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int NW  = 2 * DW + 2;  // |dx|*|f0| magnitude
    localparam int CW  = $clog2(NW + 1);
    localparam logic signed [DW+1:0] SMAX = (DW+2)'((64'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [DW+1:0] SMIN = -SMAX - 1;
    localparam logic signed [DW+1:0] CMAX = {2'b00, {DW{1'b1}}};
    localparam logic signed [DW+1:0] CMIN = -CMAX - 1;

    logic signed [DW-1:0] r_x0, r_x1, r_x, r_f0, r_f1, r_f;
    logic signed [DW-1:0] r_acc, r_ex;
    logic [1:0]           r_hstep;
    logic                 r_ebusy, r_edone;
    logic signed [PW-1:0] r_prod;
    logic                 r_pvalid;

    logic signed [PW-1:0]   n_prod;
    logic signed [PW-FRAC_BITS-1:0] v_shift;
    logic signed [DW+1:0]   v_sum, v_sat;
    logic signed [DW-1:0]   v_coef;

    logic signed [DW:0]   v_dx, v_den;
    logic [DW:0]          v_mdx, v_mden;
    logic [DW-1:0]        v_mf0;
    logic [NW-1:0]        r_num;
    logic [DW:0]          r_den;
    logic                 r_neg;
    logic                 r_mdone;
    logic [NW-1:0]        r_quo;
    logic [DW+1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_dbusy, r_ddone;
    logic [DW+1:0]        v_trial;

    logic signed [DW+1:0] v_step, v_xn;
    logic [DW-1:0]        v_mf;

    // Horner: one multiplier; each product is registered, then added to the next coefficient and saturated.
    assign n_prod  = PW'(r_acc) * PW'(r_ex);
    assign v_shift = (PW-FRAC_BITS)'(r_prod >>> FRAC_BITS);
    always_comb begin
        case (r_hstep)
            2'd0:    v_coef = i_c2;
            2'd1:    v_coef = i_c1;
            default: v_coef = i_c0;
        endcase
        if (v_shift > (PW-FRAC_BITS)'(CMAX))
            v_sum = CMAX;
        else if (v_shift < (PW-FRAC_BITS)'(CMIN))
            v_sum = CMIN;
        else
            v_sum = (DW+2)'(v_shift);
        v_sum = v_sum + (DW+2)'(v_coef);
        if (v_sum > SMAX)      v_sat = SMAX;
        else if (v_sum < SMIN) v_sat = SMIN;
        else                   v_sat = v_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebusy  <= 1'b0;
            r_edone  <= 1'b0;
            r_pvalid <= 1'b0;
            r_hstep  <= 2'd0;
        end else begin
            r_edone <= !i_cmd.eval_start && r_ebusy && r_pvalid && (r_hstep == 2'd2);
            if (i_cmd.eval_start) begin
                r_ebusy  <= 1'b1;
                r_pvalid <= 1'b0;
                r_hstep  <= 2'd0;
                r_acc    <= i_c3;
                case (i_cmd.eval_sel)
                    SEL_X0:  r_ex <= i_cmd.load ? i_guess_low : r_x0;
                    SEL_X1:  r_ex <= r_x1;
                    default: r_ex <= i_cmd.step ? DW'(v_xn) : r_x;
                endcase
            end else if (r_ebusy) begin
                if (!r_pvalid) begin
                    r_prod   <= n_prod;
                    r_pvalid <= 1'b1;
                end else begin
                    r_acc    <= DW'(v_sat);
                    r_pvalid <= 1'b0;
                    r_hstep  <= r_hstep + 2'd1;
                    if (r_hstep == 2'd2)
                        r_ebusy <= 1'b0;
                end
            end
        end
    end

    // Chord numerator |dx|*|f0| and divider by |f0-f1|.
    assign v_dx   = (DW+1)'(r_x0) - (DW+1)'(r_x1);
    assign v_den  = (DW+1)'(r_f0) - (DW+1)'(r_f1);
    assign v_mdx  = v_dx[DW] ? (DW+1)'(-v_dx) : (DW+1)'(v_dx);
    assign v_mden = v_den[DW] ? (DW+1)'(-v_den) : (DW+1)'(v_den);
    assign v_mf0  = r_f0[DW-1] ? DW'(-r_f0) : DW'(r_f0);
    assign v_trial = {r_rem[DW:0], r_quo[NW-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdone <= 1'b0;
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_mdone <= i_cmd.mul_start;
            r_ddone <= !i_cmd.div_start && r_dbusy && (r_cnt == CW'(1));
            if (i_cmd.mul_start) begin
                r_num   <= NW'(v_mdx) * NW'(v_mf0);
                r_den   <= v_mden;
                r_neg   <= (v_dx[DW] ^ r_f0[DW-1]) ^ v_den[DW];
            end
            if (i_cmd.div_start) begin
                r_quo   <= r_num;
                r_rem   <= '0;
                r_cnt   <= CW'(NW);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (!v_trial[DW+1]) begin
                    r_rem <= v_trial;
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DW:0], r_quo[NW-1]};
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1))
                    r_dbusy <= 1'b0;
            end
        end
    end

    // Quotient is bounded by |dx|, so DW+1 bits suffice.
    assign v_step = r_neg ? -(DW+2)'(r_quo[DW:0]) : (DW+2)'(r_quo[DW:0]);
    assign v_xn   = (DW+2)'(r_x0) - v_step;

    assign v_mf = r_f[DW-1] ? DW'(-r_f) : DW'(r_f);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_guess_low;
            r_x1 <= i_guess_high;
        end
        if (i_cmd.store_f0) r_f0 <= r_acc;
        if (i_cmd.store_f1) r_f1 <= r_acc;
        if (i_cmd.store_f)  r_f  <= r_acc;
        if (i_cmd.step)     r_x  <= DW'(v_xn);
        if (i_cmd.keep) begin
            if (r_f[DW-1] != r_f0[DW-1]) begin
                r_x1 <= r_x;
                r_f1 <= r_f;
            end else begin
                r_x0 <= r_x;
                r_f0 <= r_f;
            end
        end
        if (i_cmd.set_res) begin
            case (i_cmd.res_kind)
                RES_LO_ZERO:    begin o_root <= r_x0; o_residual <= '0;  end
                RES_HI_ZERO:    begin o_root <= r_x1; o_residual <= '0;  end
                RES_NO_BRACKET: begin o_root <= r_x0; o_residual <= r_f0; end
                default:        begin o_root <= r_x;  o_residual <= r_f;  end
            endcase
        end
    end

    assign o_stat.eval_done  = r_edone;
    assign o_stat.mul_done   = r_mdone;
    assign o_stat.div_done   = r_ddone;
    assign o_stat.f0_zero    = (r_f0 == '0);
    assign o_stat.f1_zero    = (r_f1 == '0);
    assign o_stat.same_sign  = (r_f0[DW-1] == r_f1[DW-1]);
    assign o_stat.within_tol = ({1'b0, i_tol} >= v_mf) && !(r_f[DW-1] && v_mf[DW-1]);
endmodule

### rtl/rfru_ctrl.sv
// Controller FSM sequencing evaluation, chord step and result for each request.
// Depends on rfru_pkg.
module rfru_ctrl
    import rfru_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_req_valid,
    output logic   o_req_ready,
    output logic   o_res_valid,
    input  logic   i_res_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic [6:0] o_iterations,
    output logic [1:0] o_status
);
    localparam int IW = $clog2(MAX_ITERATIONS + 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_iter, n_iter;
    logic          r_res_valid, n_res_valid;
    t_status       r_status, n_status;
    t_res_kind     r_kind, n_kind;
    logic          v_accept;
    logic          v_stop_chk;
    logic          v_stop_test;

    assign o_req_ready  = (r_state == S_IDLE) && !r_res_valid;
    assign v_accept     = i_req_valid && o_req_ready;
    assign v_stop_chk   = i_stat.f0_zero || i_stat.f1_zero || i_stat.same_sign;
    assign v_stop_test  = i_stat.within_tol || (r_iter == IW'(MAX_ITERATIONS));
    assign o_res_valid  = r_res_valid;
    assign o_status     = r_status;
    assign o_iterations = 7'(r_iter);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (v_accept) n_state = S_EVAL_LO;
            S_EVAL_LO: if (i_stat.eval_done) n_state = S_EVAL_HI;
            S_EVAL_HI: if (i_stat.eval_done) n_state = S_CHECK;
            S_CHECK:   n_state = v_stop_chk ? S_DONE : S_MUL;
            S_MUL:     if (i_stat.mul_done) n_state = S_DIV;
            S_DIV:     if (i_stat.div_done) n_state = S_STEP;
            S_STEP:    n_state = S_EVAL_X;
            S_EVAL_X:  if (i_stat.eval_done) n_state = S_TEST;
            S_TEST:    n_state = v_stop_test ? S_DONE : S_CHECK;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load       = v_accept;
                o_cmd.eval_start = v_accept;
                o_cmd.eval_sel   = SEL_X0;
            end
            S_EVAL_LO: begin
                o_cmd.store_f0   = i_stat.eval_done;
                o_cmd.eval_start = i_stat.eval_done;
                o_cmd.eval_sel   = SEL_X1;
            end
            S_EVAL_HI: o_cmd.store_f1  = i_stat.eval_done;
            S_CHECK:   o_cmd.mul_start = !v_stop_chk;
            S_MUL:     o_cmd.div_start = i_stat.mul_done;
            S_STEP: begin
                o_cmd.step       = 1'b1;
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel   = SEL_X;
            end
            S_EVAL_X:  o_cmd.store_f = i_stat.eval_done;
            S_TEST:    o_cmd.keep    = !v_stop_test;
            S_DONE: begin
                o_cmd.set_res  = 1'b1;
                o_cmd.res_kind = r_kind;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_iter      = r_iter;
        n_res_valid = r_res_valid;
        n_status    = r_status;
        n_kind      = r_kind;
        if (v_accept)
            n_iter = '0;
        else if (r_state == S_STEP)
            n_iter = r_iter + IW'(1);
        if (r_state == S_DONE)
            n_res_valid = 1'b1;
        else if (i_res_ready)
            n_res_valid = 1'b0;
        if (r_state == S_CHECK && v_stop_chk) begin
            if (i_stat.f0_zero) begin
                n_status = ST_OK;
                n_kind   = RES_LO_ZERO;
            end else if (i_stat.f1_zero) begin
                n_status = ST_OK;
                n_kind   = RES_HI_ZERO;
            end else begin
                n_status = ST_NO_BRACKET;
                n_kind   = RES_NO_BRACKET;
            end
        end
        if (r_state == S_TEST && v_stop_test) begin
            n_status = i_stat.within_tol ? ST_OK : ST_ITER_LIMIT;
            n_kind   = RES_CHORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_iter      <= '0;
            r_status    <= ST_OK;
            r_kind      <= RES_LO_ZERO;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_iter      <= n_iter;
            r_status    <= n_status;
            r_kind      <= n_kind;
        end
    end
endmodule

### rtl/regula_falsi_root_finder_unit.sv
// Regula falsi root finder for a cubic in signed Q16.16; top level with APB registers.
// A request ends without a chord step when an endpoint decides it; each chord step runs
// a multiply, a serial divide, a Horner evaluation and control states.
// Throughput: one request at a time; the next is taken once the result is accepted.
// Reset (synchronous, active low) restores the default coefficients and tolerance.
// Depends on rfru_pkg, rfru_if, rfru_ctrl, rfru_datapath.
module regula_falsi_root_finder_unit
    import rfru_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRAC_BITS      = 16,
    parameter int DATA_WIDTH     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfru_req_if.sink              i_req,
    rfru_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic signed [DATA_WIDTH-1:0] r_c3, r_c2, r_c1, r_c0;
    logic [DATA_WIDTH-2:0]        r_tol;
    logic [2:0]                   v_idx;

    assign pready = 1'b1;
    assign v_idx  = paddr[REG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3  <= '0;
            r_c2  <= DATA_WIDTH'(65536);
            r_c1  <= DATA_WIDTH'(262144);
            r_c0  <= DATA_WIDTH'(327680);
            r_tol <= (DATA_WIDTH-1)'(66);
        end else if (psel && penable && pwrite) begin
            case (v_idx)
                REG_CUBIC:  r_c3  <= DATA_WIDTH'(signed'(pwdata));
                REG_SQUARE: r_c2  <= DATA_WIDTH'(signed'(pwdata));
                REG_LINEAR: r_c1  <= DATA_WIDTH'(signed'(pwdata));
                REG_CONST:  r_c0  <= DATA_WIDTH'(signed'(pwdata));
                REG_TOL:    r_tol <= (DATA_WIDTH-1)'(pwdata[30:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (v_idx)
            REG_CUBIC:  prdata = 32'(r_c3);
            REG_SQUARE: prdata = 32'(r_c2);
            REG_LINEAR: prdata = 32'(r_c1);
            REG_CONST:  prdata = 32'(r_c0);
            REG_TOL:    prdata = 32'(r_tol);
            default:    prdata = '0;
        endcase
    end

    t_cmd  w_cmd;
    t_stat w_stat;

    rfru_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_iterations (o_res.iterations),
        .o_status     (o_res.status)
    );

    rfru_datapath #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_guess_low  (i_req.guess_low),
        .i_guess_high (i_req.guess_high),
        .i_c3         (r_c3),
        .i_c2         (r_c2),
        .i_c1         (r_c1),
        .i_c0         (r_c0),
        .i_tol        (r_tol),
        .o_root       (o_res.root),
        .o_residual   (o_res.residual)
    );
endmodule
